// ===== design/csvft_pkg.sv =====
// Shared types and constants for the CSV field tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package csvft_pkg;

    localparam logic [7:0] QUOTE_CH    = 8'h22;
    localparam logic [7:0] LF_CH       = 8'h0A;
    localparam logic [7:0] CR_CH       = 8'h0D;
    localparam logic [7:0] SPACE_CH    = 8'h20;
    localparam logic [7:0] HT_CH       = 8'h09;
    localparam logic [7:0] DELIM_RESET = 8'd59;

    // Register index decoded from paddr[2]
    localparam logic REG_DELIMITER = 1'b0;

    // Result queue: four entries, two-bit pointers wrap on their own
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    typedef struct packed {
        logic       result_last;
        logic       is_header;
        logic       row_blank;
        logic       row_end;
        logic       field_end;
        logic       byte_valid;
        logic [7:0] out_byte;
    } result_t;

    // HT, LF, VT, FF, CR or space
    function automatic logic is_space(input logic [7:0] b);
        return ((b >= HT_CH) && (b <= CR_CH)) || (b == SPACE_CH);
    endfunction

endpackage
`default_nettype wire

// ===== design/csv_field_tokenizer_core.sv =====
// Top level of the CSV field tokenizer: byte parser, result queue and APB register.
// A result is registered in the result queue and offered on m_tvalid from there.
// Bytes are taken one per cycle while m_tready is high and each byte yields at most
// one result; a byte that yields two results puts both into the queue for the output.
// Input is taken while the four-entry result queue holds two entries or fewer.
// Reset (rst_n low, asynchronous) clears all parse flags, empties the queue and sets
// the delimiter to ';'.
`timescale 1ns / 1ps
`default_nettype none
module csv_field_tokenizer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,   // end_of_text
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [7:0]       m_tuser,   // [0] byte_valid, [1] field_end, [2] row_end,
                                        // [3] row_blank, [4] is_header, [7:5] zero
    output logic             m_tlast    // result_last
);
    import csvft_pkg::*;

    logic [7:0] delimiter_reg;

    logic in_quotes_reg, in_quotes_next;
    logic quote_pending_reg, quote_pending_next;
    logic cr_pending_reg, cr_pending_next;
    logic field_nonempty_reg, field_nonempty_next;
    logic row_has_separator_reg, row_has_separator_next;
    logic row_has_content_reg, row_has_content_next;
    logic header_seen_reg, header_seen_next;

    result_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic    s_fire, m_fire;
    logic    have0, have1;
    result_t res0, res1;
    result_t head;

    logic [7:0] b;
    logic       handled;
    logic       act_put, act_sep, act_row;
    logic [7:0] put_val;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_DELIMITER)
        begin
            prdata = {24'd0, delimiter_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DELIM_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_DELIMITER))
        begin
            delimiter_reg <= pwdata[7:0];
        end
    end

    // ---------------------------------------------------------------- handshake
    assign s_tready = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_fire   = m_tvalid && m_tready;

    // ---------------------------------------------------------------- parser
    assign b = s_tdata;

    always_comb
    begin
        in_quotes_next         = in_quotes_reg;
        quote_pending_next     = quote_pending_reg;
        cr_pending_next        = cr_pending_reg;
        field_nonempty_next    = field_nonempty_reg;
        row_has_separator_next = row_has_separator_reg;
        row_has_content_next   = row_has_content_reg;
        header_seen_next       = header_seen_reg;
        handled = 1'b0;
        act_put = 1'b0;
        act_sep = 1'b0;
        act_row = 1'b0;
        put_val = b;
        have0   = 1'b0;
        have1   = 1'b0;
        res0    = '0;
        res1    = '0;

        // Swallow the LF of a CRLF
        if (cr_pending_reg)
        begin
            cr_pending_next = 1'b0;
            handled         = (b == LF_CH);
        end

        // Resolve a quote seen inside quotes: doubled quote or closing quote
        if (!handled && quote_pending_reg)
        begin
            quote_pending_next = 1'b0;
            if (b == QUOTE_CH)
            begin
                act_put = 1'b1;
                handled = 1'b1;
            end
            else
            begin
                in_quotes_next = 1'b0;
            end
        end

        if (!handled)
        begin
            if (in_quotes_next)
            begin
                if (b == QUOTE_CH)
                begin
                    quote_pending_next = 1'b1;
                end
                else
                begin
                    act_put = 1'b1;
                end
            end
            else if (b == QUOTE_CH)
            begin
                in_quotes_next = 1'b1;
            end
            else if (b == delimiter_reg)
            begin
                act_sep = 1'b1;
            end
            else if ((b == LF_CH) || (b == CR_CH))
            begin
                act_row = 1'b1;
                if (b == CR_CH)
                begin
                    cr_pending_next = 1'b1;
                end
            end
            else
            begin
                act_put = 1'b1;
            end
        end

        res0.is_header = !header_seen_reg;
        if (act_put)
        begin
            have0               = 1'b1;
            res0.out_byte       = put_val;
            res0.byte_valid     = 1'b1;
            field_nonempty_next = 1'b1;
            if (!is_space(put_val))
            begin
                row_has_content_next = 1'b1;
            end
        end
        else if (act_sep)
        begin
            have0                  = 1'b1;
            res0.field_end         = 1'b1;
            field_nonempty_next    = 1'b0;
            row_has_separator_next = 1'b1;
        end
        else if (act_row)
        begin
            have0          = 1'b1;
            res0.field_end = 1'b1;
            res0.row_end   = 1'b1;
            res0.row_blank = !row_has_content_reg;
            if (row_has_content_reg)
            begin
                header_seen_next = 1'b1;
            end
            field_nonempty_next    = 1'b0;
            row_has_separator_next = 1'b0;
            row_has_content_next   = 1'b0;
        end

        // End of text: flush an unfinished row, then start over
        if (s_tlast)
        begin
            if (field_nonempty_next || row_has_separator_next)
            begin
                res1.is_header = !header_seen_reg;
                res1.field_end = 1'b1;
                res1.row_end   = 1'b1;
                res1.row_blank = !row_has_content_next;
                if (have0)
                begin
                    have1 = 1'b1;
                end
                else
                begin
                    have0 = 1'b1;
                    res0  = res1;
                end
            end
            in_quotes_next         = 1'b0;
            quote_pending_next     = 1'b0;
            cr_pending_next        = 1'b0;
            field_nonempty_next    = 1'b0;
            row_has_separator_next = 1'b0;
            row_has_content_next   = 1'b0;
            header_seen_next       = 1'b0;
        end

        res0.result_last = have0 && !have1;
        res1.result_last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg         <= 1'b0;
            quote_pending_reg     <= 1'b0;
            cr_pending_reg        <= 1'b0;
            field_nonempty_reg    <= 1'b0;
            row_has_separator_reg <= 1'b0;
            row_has_content_reg   <= 1'b0;
            header_seen_reg       <= 1'b0;
        end
        else if (s_fire)
        begin
            in_quotes_reg         <= in_quotes_next;
            quote_pending_reg     <= quote_pending_next;
            cr_pending_reg        <= cr_pending_next;
            field_nonempty_reg    <= field_nonempty_next;
            row_has_separator_reg <= row_has_separator_next;
            row_has_content_reg   <= row_has_content_next;
            header_seen_reg       <= header_seen_next;
        end
    end

    // ---------------------------------------------------------------- result queue
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (s_fire)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(have0) + PTR_W'(have1);
            count_next  = count_next + CNT_W'(have0) + CNT_W'(have1);
        end
        if (m_fire)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
            count_next  = count_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && have0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (s_fire && have1)
        begin
            queue_reg[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    assign head    = queue_reg[rd_ptr_reg];
    assign m_tdata = head.out_byte;
    assign m_tuser = {3'b000, head.is_header, head.row_blank, head.row_end,
                      head.field_end, head.byte_valid};
    assign m_tlast = head.result_last;

    // ---------------------------------------------------------------- assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |-> (count_reg <= CNT_W'(QUEUE_DEPTH - 2)))
        else $error("byte taken without room for two results");

    a_quote_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
        quote_pending_reg |-> in_quotes_reg)
        else $error("pending quote outside a quoted field");

    a_pending_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(quote_pending_reg && cr_pending_reg))
        else $error("quote and CR pending together");

    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_tlast) |=> (!in_quotes_reg && !header_seen_reg && !cr_pending_reg
                                 && !field_nonempty_reg && !row_has_separator_reg))
        else $error("state not cleared after end of text");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the CSV field tokenizer: byte stream in, field and row marks out.
`timescale 1ns / 1ps
module tb_top;
    import csvft_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 147;
    localparam int NUM_PHASES    = 9;
    localparam int REPORT_LIMIT  = 10;

    // Tracks the tokenizer state and holds the field/row marks still to come
    class token_board;
        logic [7:0] delim;
        bit         in_quotes;
        bit         quote_pending;
        bit         cr_pending;
        bit         field_nonempty;
        bit         row_has_sep;
        bit         row_has_content;
        bit         header_seen;
        result_t    due_tokens[$];
        result_t    step_tokens[$];
        int         mismatches;

        function new();
            delim      = DELIM_RESET;
            mismatches = 0;
            restart_text();
        endfunction

        function void restart_text();
            in_quotes       = 1'b0;
            quote_pending   = 1'b0;
            cr_pending      = 1'b0;
            field_nonempty  = 1'b0;
            row_has_sep     = 1'b0;
            row_has_content = 1'b0;
            header_seen     = 1'b0;
        endfunction

        function void push_token(logic [7:0] b, bit bv, bit fend, bit rend, bit blank);
            result_t r;
            if (step_tokens.size() >= 2)
                return;
            r.out_byte    = bv ? b : 8'h00;
            r.byte_valid  = bv;
            r.field_end   = fend;
            r.row_end     = rend;
            r.row_blank   = rend && blank;
            r.is_header   = !header_seen;
            r.result_last = 1'b0;
            step_tokens.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b);
            push_token(b, 1'b1, 1'b0, 1'b0, 1'b0);
            field_nonempty = 1'b1;
            if (!((b >= HT_CH && b <= CR_CH) || b == SPACE_CH))
                row_has_content = 1'b1;
        endfunction

        function void close_row();
            push_token(8'h00, 1'b0, 1'b1, 1'b1, !row_has_content);
            if (row_has_content)
                header_seen = 1'b1;
            field_nonempty  = 1'b0;
            row_has_sep     = 1'b0;
            row_has_content = 1'b0;
        endfunction

        // Work out the marks one accepted byte causes and queue them
        function void note_byte(logic [7:0] b, logic eot);
            bit      handled;
            result_t r;
            handled = 1'b0;
            step_tokens.delete();
            if (cr_pending)
            begin
                cr_pending = 1'b0;
                if (b == LF_CH)
                    handled = 1'b1;
            end
            if (!handled && quote_pending)
            begin
                quote_pending = 1'b0;
                if (b == QUOTE_CH)
                begin
                    take_byte(QUOTE_CH);
                    handled = 1'b1;
                end
                else
                    in_quotes = 1'b0;
            end
            if (!handled)
            begin
                if (in_quotes)
                begin
                    if (b == QUOTE_CH)
                        quote_pending = 1'b1;
                    else
                        take_byte(b);
                end
                else if (b == QUOTE_CH)
                    in_quotes = 1'b1;
                else if (b == delim)
                begin
                    push_token(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                    field_nonempty = 1'b0;
                    row_has_sep    = 1'b1;
                end
                else if (b == LF_CH || b == CR_CH)
                begin
                    close_row();
                    if (b == CR_CH)
                        cr_pending = 1'b1;
                end
                else
                    take_byte(b);
            end
            if (eot)
            begin
                // flush a pending row, then start afresh with a new header
                if (field_nonempty || row_has_sep)
                    close_row();
                restart_text();
            end
            if (step_tokens.size() > 0)
            begin
                r = step_tokens.pop_back();
                r.result_last = 1'b1;
                step_tokens.push_back(r);
            end
            foreach (step_tokens[i])
                due_tokens.push_back(step_tokens[i]);
        endfunction

        function void report(string what, result_t want, result_t got, logic [2:0] pad);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("%0t %s: want byte=%02h v=%0b fe=%0b re=%0b bl=%0b hdr=%0b last=%0b",
                         $realtime, what,
                         want.out_byte, want.byte_valid, want.field_end, want.row_end,
                         want.row_blank, want.is_header, want.result_last);
                $display("    got byte=%02h v=%0b fe=%0b re=%0b bl=%0b hdr=%0b last=%0b pad=%0h",
                         got.out_byte, got.byte_valid, got.field_end, got.row_end,
                         got.row_blank, got.is_header, got.result_last, pad);
            end
        endfunction

        function void check_token(logic [7:0] data, logic [7:0] user, logic last);
            result_t got;
            result_t want;
            got = result_t'({last, user[4:0], data});
            if (due_tokens.size() == 0)
            begin
                report("unexpected transfer", '0, got, user[7:5]);
                return;
            end
            want = due_tokens.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.field_end !== want.field_end || got.row_end !== want.row_end ||
                got.row_blank !== want.row_blank || got.is_header !== want.is_header ||
                got.result_last !== want.result_last || user[7:5] !== 3'b000)
                report("mismatch", want, got, user[7:5]);
        endfunction
    endclass

    typedef struct packed {
        logic       eot;
        logic [7:0] b;
    } text_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [7:0]  m_tuser;
    logic        m_tlast;

    logic [15:0] ready_pattern = 16'hFFFF;
    int unsigned ready_phase = 0;
    int unsigned max_gap = 0;
    text_byte_t  text_q[$];
    token_board  board;

    csv_field_tokenizer_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready    <= ready_pattern[ready_phase % 16];
        ready_phase <= ready_phase + 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                board.check_token(m_tdata, m_tuser, m_tlast);
        end
    end

    function automatic void queue_byte(logic [7:0] b, logic eot);
        text_byte_t t;
        t.b   = b;
        t.eot = eot;
        text_q.push_back(t);
    endfunction

    // Unquoted field content: printable, with some whitespace, never quote or delimiter
    function automatic logic [7:0] plain_char(logic [7:0] delim);
        logic [7:0] c;
        do
        begin
            case ($urandom_range(0, 9))
                0: c = SPACE_CH;
                1: c = HT_CH;
                2: c = 8'h0B + 8'($urandom_range(0, 1));  // VT or FF
                default: c = 8'($urandom_range(33, 126));
            endcase
        end
        while (c == QUOTE_CH || c == delim);
        return c;
    endfunction

    // One text of a few rows; sometimes cut short or left open for the next one
    task automatic add_text(logic [7:0] delim);
        int unsigned rows;
        int unsigned fields;
        int unsigned start;
        int unsigned cut;
        text_byte_t  t;
        start = text_q.size();
        rows  = $urandom_range(1, 4);
        for (int r = 0; r < rows; r++)
        begin
            fields = $urandom_range(1, 4);
            for (int f = 0; f < fields; f++)
            begin
                if (f > 0)
                    queue_byte(delim, 1'b0);
                case ($urandom_range(0, 5))
                    0: ;
                    1, 2:
                        repeat ($urandom_range(1, 6))
                            queue_byte(plain_char(delim), 1'b0);
                    3:
                        repeat ($urandom_range(1, 3))
                            queue_byte(delim == SPACE_CH ? HT_CH : SPACE_CH, 1'b0);
                    default:
                    begin
                        queue_byte(QUOTE_CH, 1'b0);
                        repeat ($urandom_range(0, 6))
                        begin
                            case ($urandom_range(0, 7))
                                0:
                                begin
                                    queue_byte(QUOTE_CH, 1'b0);
                                    queue_byte(QUOTE_CH, 1'b0);
                                end
                                1: queue_byte(delim, 1'b0);
                                2: queue_byte($urandom_range(0, 1) ? CR_CH : LF_CH, 1'b0);
                                3: queue_byte(8'($urandom_range(0, 255)), 1'b0);
                                default: queue_byte(plain_char(delim), 1'b0);
                            endcase
                        end
                        queue_byte(QUOTE_CH, 1'b0);
                    end
                endcase
            end
            if (r != rows - 1 || $urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 2))
                    0: queue_byte(LF_CH, 1'b0);
                    1: queue_byte(CR_CH, 1'b0);
                    default:
                    begin
                        queue_byte(CR_CH, 1'b0);
                        queue_byte(LF_CH, 1'b0);
                    end
                endcase
            end
        end
        if (text_q.size() == start)
            queue_byte(plain_char(delim), 1'b0);
        // break the text off at a random byte now and then
        if ($urandom_range(0, 5) == 0)
        begin
            cut = $urandom_range(start, text_q.size() - 1);
            while (text_q.size() > cut + 1)
                void'(text_q.pop_back());
        end
        if ($urandom_range(0, 3) != 0)
        begin
            t = text_q.pop_back();
            t.eot = 1'b1;
            text_q.push_back(t);
        end
    endtask

    task automatic add_noise(logic [7:0] delim);
        logic eot;
        repeat ($urandom_range(1, 8))
        begin
            eot = ($urandom_range(0, 11) == 0);
            case ($urandom_range(0, 6))
                0: queue_byte(QUOTE_CH, eot);
                1: queue_byte(delim, eot);
                2: queue_byte(CR_CH, eot);
                3: queue_byte(LF_CH, eot);
                default: queue_byte(8'($urandom_range(0, 255)), eot);
            endcase
        end
    endtask

    // Send the queued text in bursts with random idle gaps between them
    task automatic send_text();
        int unsigned burst;
        int unsigned gap;
        text_byte_t  t;
        burst = $urandom_range(1, 20);
        while (text_q.size() > 0)
        begin
            t = text_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= t.b;
            s_tlast  <= t.eot;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 20);
                gap   = $urandom_range(0, max_gap);
                if (gap > 0 && text_q.size() > 0)
                begin
                    s_tvalid <= 1'b0;
                    s_tdata  <= 8'($urandom);
                    repeat (gap)
                        @(posedge clk);
                end
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // Hold until every expected transfer has arrived, then let swallowed bytes settle
    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        while (board.due_tokens.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_delimiter(logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DELIMITER, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.delim = value;
    endtask

    initial
    begin
        logic [7:0] phase_delims [NUM_PHASES];
        phase_delims = '{DELIM_RESET, 8'h00, 8'hFF, QUOTE_CH, CR_CH, LF_CH, 8'd44, HT_CH,
                         8'h00};
        phase_delims[NUM_PHASES - 1] = 8'($urandom_range(0, 255));
        board = new();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain byte, separator, quoted field with a doubled quote and extreme bytes
        queue_byte("a", 1'b0);
        queue_byte(DELIM_RESET, 1'b0);
        queue_byte(QUOTE_CH, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(QUOTE_CH, 1'b0);
        queue_byte(QUOTE_CH, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(QUOTE_CH, 1'b0);
        queue_byte(DELIM_RESET, 1'b0);
        // CRLF ends one row only; then a whitespace row and an empty row
        queue_byte(CR_CH, 1'b0);
        queue_byte(LF_CH, 1'b0);
        queue_byte(SPACE_CH, 1'b0);
        queue_byte(HT_CH, 1'b0);
        queue_byte(LF_CH, 1'b0);
        queue_byte(CR_CH, 1'b0);
        // quote straight after CR, line break and separator inside quotes,
        // end of text on a doubled quote
        queue_byte(QUOTE_CH, 1'b0);
        queue_byte(LF_CH, 1'b0);
        queue_byte(DELIM_RESET, 1'b0);
        queue_byte(QUOTE_CH, 1'b0);
        queue_byte(QUOTE_CH, 1'b1);
        // end of text on a closing quote, then on a swallowed LF
        queue_byte(QUOTE_CH, 1'b0);
        queue_byte("z", 1'b0);
        queue_byte(QUOTE_CH, 1'b1);
        queue_byte(CR_CH, 1'b0);
        queue_byte(LF_CH, 1'b1);
        send_text();
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_delimiter(phase_delims[p]);
            max_gap = (p % 3 == 0) ? 0 : $urandom_range(1, 6);
            ready_pattern <= (p % 4 == 3) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            while (text_q.size() < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 4) == 0)
                    add_noise(phase_delims[p]);
                else
                    add_text(phase_delims[p]);
            end
            send_text();
            wait_idle();
        end

        if (board.mismatches == 0 && board.due_tokens.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
